[hdl/analog_ladder_key_debouncer_top_defines.svh]
// Assertion macros shared by the ladder key debouncer RTL.
// Bodies assume a clock clk_i and an active-low reset rst_ni in scope.
`ifndef ANALOG_LADDER_KEY_DEBOUNCER_TOP_DEFINES_SVH
`define ANALOG_LADDER_KEY_DEBOUNCER_TOP_DEFINES_SVH

// Same-cycle implication.
`define ALKD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ALKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/alkd_pkg.sv]
// Shared types and constants for the resistor-ladder key debouncer.
// No dependencies; used by alkd_decode and analog_ladder_key_debouncer_top.
package alkd_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned TIME_BITS_DEF   = 32;

  localparam int unsigned MV_BITS   = 12;
  localparam int unsigned TOL_BITS  = 10;
  localparam int unsigned LONG_BITS = 16;
  localparam int unsigned DEB_BITS  = 10;
  localparam int unsigned NUM_KEYS  = 5;
  localparam int unsigned KEY_BITS  = 3;

  localparam int unsigned NO_KEY_MV      = 2800;
  localparam int unsigned FALLBACK_SCALE = 7;

  typedef logic [KEY_BITS-1:0] key_t;
  localparam key_t KEY_NONE = 3'd0;
  localparam key_t KEY_MAX  = 3'd5;

  typedef logic [NUM_KEYS-1:0][MV_BITS-1:0] nom_arr_t;

  typedef struct packed {
    nom_arr_t              nom_mv;
    logic [TOL_BITS-1:0]   tol_mv;
    logic [LONG_BITS-1:0]  long_ms;
    logic [DEB_BITS-1:0]   deb_ms;
  } cfg_t;

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 4;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_KEY1     = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY2     = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY3     = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY4     = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY5     = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOL      = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG     = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE = 4'd7;

  localparam nom_arr_t NOM_RST = {12'd2300, 12'd1800, 12'd1300, 12'd800, 12'd300};
  localparam logic [TOL_BITS-1:0]  TOL_RST  = 10'd100;
  localparam logic [LONG_BITS-1:0] LONG_RST = 16'd1000;
  localparam logic [DEB_BITS-1:0]  DEB_RST  = 10'd30;

endpackage

[hdl/analog_ladder_key_debouncer_top.sv]
// Resistor-ladder keypad debouncer with long-press release events.
// Depends on alkd_pkg, alkd_decode and analog_ladder_key_debouncer_top_defines.svh.

// One sample beat is taken per clock while in_stall_o is low and gives exactly
// one result beat, which reaches the result port through the input register
// and then the result register. The sustained rate is one item per cycle while
// the result is not stalled: key decode and the debounce/hold state update are
// combinational between the input register and the result register. A stalled
// result holds the input register full; a third beat is then refused until the
// result drains. Configuration writes are always ready and take effect on the
// next sample processed; write them only while no sample is in flight.
`include "analog_ladder_key_debouncer_top_defines.svh"

module analog_ladder_key_debouncer_top #(
  parameter int unsigned SAMPLE_BITS = alkd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TIME_BITS   = alkd_pkg::TIME_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [alkd_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [alkd_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [SAMPLE_BITS-1:0]             sample_mv_i,
  input  logic [TIME_BITS-1:0]               now_ms_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               event_valid_o,
  output logic [alkd_pkg::KEY_BITS-1:0]      event_key_o,
  output logic                               long_press_o,
  output logic [TIME_BITS-1:0]               event_ms_o,
  output logic [alkd_pkg::KEY_BITS-1:0]      held_key_o
);

  alkd_pkg::cfg_t cfg_q;

  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_mv_q;
  logic [TIME_BITS-1:0]   s1_now_q;

  alkd_pkg::key_t         raw_key_q;
  logic [TIME_BITS-1:0]   raw_chg_q, raw_chg_d;
  alkd_pkg::key_t         held_key_q, held_key_d;
  logic [TIME_BITS-1:0]   press_q, press_d;

  logic                   out_valid_q;
  logic                   ev_valid_q, ev_valid_d;
  alkd_pkg::key_t         ev_key_q, ev_key_d;
  logic                   ev_long_q, ev_long_d;
  logic [TIME_BITS-1:0]   ev_ms_q, ev_ms_d;
  alkd_pkg::key_t         held_out_q;

  alkd_pkg::key_t         rk;
  logic [TIME_BITS-1:0]   since_chg, hold, deb_t, long_t;
  logic                   settled;
  logic                   in_fire, s1_fire, out_fire;

  assign cfg_ready_o = 1'b1;

  // stage 1 moves on unless a result is waiting and stalled
  assign s1_fire    = s1_valid_q & ~(out_valid_q & out_stall_i);
  assign out_fire   = out_valid_q & ~out_stall_i;
  assign in_stall_o = s1_valid_q & out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  alkd_decode #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_decode (
    .sample_mv_i(s1_mv_q),
    .nom_mv_i   (cfg_q.nom_mv),
    .tol_mv_i   (cfg_q.tol_mv),
    .key_o      (rk)
  );

  always_comb begin
    deb_t     = TIME_BITS'(cfg_q.deb_ms);
    long_t    = TIME_BITS'(cfg_q.long_ms);
    raw_chg_d = (rk != raw_key_q) ? s1_now_q : raw_chg_q;
    since_chg = s1_now_q - raw_chg_d;
    hold      = s1_now_q - press_q;
    settled   = (since_chg >= deb_t) && (rk != held_key_q);

    held_key_d = held_key_q;
    press_d    = press_q;
    ev_valid_d = 1'b0;
    ev_key_d   = alkd_pkg::KEY_NONE;
    ev_long_d  = 1'b0;
    ev_ms_d    = '0;
    if (settled) begin
      held_key_d = rk;
      if (held_key_q == alkd_pkg::KEY_NONE) begin
        press_d = s1_now_q;
      end else begin
        press_d = (rk != alkd_pkg::KEY_NONE) ? s1_now_q : '0;
        if (hold >= deb_t) begin
          ev_valid_d = 1'b1;
          ev_key_d   = held_key_q;
          ev_long_d  = (hold >= long_t);
          ev_ms_d    = s1_now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nom_mv  <= alkd_pkg::NOM_RST;
      cfg_q.tol_mv  <= alkd_pkg::TOL_RST;
      cfg_q.long_ms <= alkd_pkg::LONG_RST;
      cfg_q.deb_ms  <= alkd_pkg::DEB_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        alkd_pkg::REG_KEY1:     cfg_q.nom_mv[0] <= cfg_wdata_i[alkd_pkg::MV_BITS-1:0];
        alkd_pkg::REG_KEY2:     cfg_q.nom_mv[1] <= cfg_wdata_i[alkd_pkg::MV_BITS-1:0];
        alkd_pkg::REG_KEY3:     cfg_q.nom_mv[2] <= cfg_wdata_i[alkd_pkg::MV_BITS-1:0];
        alkd_pkg::REG_KEY4:     cfg_q.nom_mv[3] <= cfg_wdata_i[alkd_pkg::MV_BITS-1:0];
        alkd_pkg::REG_KEY5:     cfg_q.nom_mv[4] <= cfg_wdata_i[alkd_pkg::MV_BITS-1:0];
        alkd_pkg::REG_TOL:      cfg_q.tol_mv    <= cfg_wdata_i[alkd_pkg::TOL_BITS-1:0];
        alkd_pkg::REG_LONG:     cfg_q.long_ms   <= cfg_wdata_i[alkd_pkg::LONG_BITS-1:0];
        alkd_pkg::REG_DEBOUNCE: cfg_q.deb_ms    <= cfg_wdata_i[alkd_pkg::DEB_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      raw_key_q   <= alkd_pkg::KEY_NONE;
      raw_chg_q   <= '0;
      held_key_q  <= alkd_pkg::KEY_NONE;
      press_q     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        raw_key_q  <= rk;
        raw_chg_q  <= raw_chg_d;
        held_key_q <= held_key_d;
        press_q    <= press_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mv_q  <= sample_mv_i;
      s1_now_q <= now_ms_i;
    end
    if (s1_fire) begin
      ev_valid_q <= ev_valid_d;
      ev_key_q   <= ev_key_d;
      ev_long_q  <= ev_long_d;
      ev_ms_q    <= ev_ms_d;
      held_out_q <= held_key_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_valid_o = ev_valid_q;
  assign event_key_o   = ev_key_q;
  assign long_press_o  = ev_long_q;
  assign event_ms_o    = ev_ms_q;
  assign held_key_o    = held_out_q;

  `ALKD_ASSERT_NOW(a_quiet_no_event, out_valid_o && !event_valid_o,
    event_key_o == alkd_pkg::KEY_NONE && !long_press_o && event_ms_o == '0,
    "event fields not cleared without event")
  `ALKD_ASSERT_NOW(a_event_has_key, out_valid_o && event_valid_o,
    event_key_o != alkd_pkg::KEY_NONE && event_key_o != held_key_o,
    "event reports no key or the still-held key")
  `ALKD_ASSERT_NOW(a_stall_needs_beat, in_stall_o, s1_valid_q && out_valid_q,
    "input stalled with room downstream")
  `ALKD_ASSERT_NEXT(a_blocked_holds, s1_valid_q && out_valid_q && out_stall_i,
    s1_valid_q && $stable(held_key_q) && $stable(raw_chg_q),
    "state moved while result stalled")
  `ALKD_ASSERT_NOW(a_held_range, 1'b1, held_key_q <= alkd_pkg::KEY_MAX,
    "held key out of range")

endmodule

[hdl/alkd_decode.sv]
// Combinational ladder voltage to raw key decoder (0 = no key, 1..5).
// Depends on alkd_pkg.
module alkd_decode #(
  parameter int unsigned SAMPLE_BITS = alkd_pkg::SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0]        sample_mv_i,
  input  alkd_pkg::nom_arr_t            nom_mv_i,
  input  logic [alkd_pkg::TOL_BITS-1:0] tol_mv_i,
  output alkd_pkg::key_t                key_o
);

  // all quantities stay non-negative, so plain unsigned math with headroom
  localparam int unsigned CW =
    ((SAMPLE_BITS > alkd_pkg::MV_BITS) ? SAMPLE_BITS : alkd_pkg::MV_BITS) + 2;

  logic [CW-1:0] v;
  logic [CW-1:0] floor_mv;
  logic [CW-1:0] win;
  logic [CW-1:0] nom   [alkd_pkg::NUM_KEYS];
  logic [CW-1:0] mid   [alkd_pkg::NUM_KEYS];
  logic [CW-1:0] gap   [alkd_pkg::NUM_KEYS];
  logic [CW-1:0] best_d;
  alkd_pkg::key_t best_k;
  alkd_pkg::key_t mid_k;
  logic           mid_hit;

  always_comb begin
    v        = CW'(sample_mv_i);
    floor_mv = CW'(alkd_pkg::NO_KEY_MV) - CW'(tol_mv_i);
    win      = CW'(tol_mv_i) * CW'(alkd_pkg::FALLBACK_SCALE);

    for (int k = 0; k < alkd_pkg::NUM_KEYS; k++) begin
      nom[k] = CW'(nom_mv_i[k]);
      gap[k] = (v >= nom[k]) ? (v - nom[k]) : (nom[k] - v);
    end
    for (int k = 0; k < alkd_pkg::NUM_KEYS - 1; k++) begin
      mid[k] = (nom[k] + nom[k+1]) >> 1;
    end
    mid[alkd_pkg::NUM_KEYS-1] = (nom[alkd_pkg::NUM_KEYS-1] + floor_mv) >> 1;

    // walk from the top so the lowest matching bucket wins
    mid_hit = 1'b0;
    mid_k   = alkd_pkg::KEY_NONE;
    for (int k = alkd_pkg::NUM_KEYS - 1; k >= 0; k--) begin
      if (v <= mid[k]) begin
        mid_hit = 1'b1;
        mid_k   = alkd_pkg::key_t'(k + 1);
      end
    end

    // nearest nominal, lowest key on a tie
    best_d = gap[0];
    best_k = alkd_pkg::key_t'(1);
    for (int k = 1; k < alkd_pkg::NUM_KEYS; k++) begin
      if (gap[k] < best_d) begin
        best_d = gap[k];
        best_k = alkd_pkg::key_t'(k + 1);
      end
    end

    if (v >= floor_mv) begin
      key_o = alkd_pkg::KEY_NONE;
    end else if (mid_hit) begin
      key_o = mid_k;
    end else if (best_d <= win) begin
      key_o = best_k;
    end else begin
      key_o = alkd_pkg::KEY_NONE;
    end
  end

endmodule

[test/alkd_release_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the ladder key debouncer: follows the register port, predicts the
// report of every accepted sample and compares result beats in order. Uses alkd_pkg.
module alkd_release_checker #(
  parameter int unsigned SAMPLE_BITS = alkd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TIME_BITS   = alkd_pkg::TIME_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [alkd_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [alkd_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [SAMPLE_BITS-1:0]             sample_mv_i,
  input  logic [TIME_BITS-1:0]               now_ms_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic                               event_valid_i,
  input  alkd_pkg::key_t                     event_key_i,
  input  logic                               long_press_i,
  input  logic [TIME_BITS-1:0]               event_ms_i,
  input  alkd_pkg::key_t                     held_key_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic                 event_valid;
    alkd_pkg::key_t       event_key;
    logic                 long_hit;
    logic [TIME_BITS-1:0] event_ms;
    alkd_pkg::key_t       held_key;
  } report_t;

  // register shadow
  logic [alkd_pkg::MV_BITS-1:0]   nom_mv [alkd_pkg::NUM_KEYS];
  logic [alkd_pkg::TOL_BITS-1:0]  tol_mv;
  logic [alkd_pkg::LONG_BITS-1:0] long_ms;
  logic [alkd_pkg::DEB_BITS-1:0]  deb_ms;

  // debounce state
  alkd_pkg::key_t       raw_key;
  logic [TIME_BITS-1:0] raw_chg_ms;
  alkd_pkg::key_t       held_key;
  logic [TIME_BITS-1:0] press_ms;

  report_t report_q [$];

  function automatic report_t predict_report(input logic [SAMPLE_BITS-1:0] mv,
                                             input logic [TIME_BITS-1:0]   now);
    report_t              rep;
    int                   v, floor_mv, thr, near_delta, d;
    int                   nom [alkd_pkg::NUM_KEYS];
    bit                   found;
    alkd_pkg::key_t       raw, best;
    logic [TIME_BITS-1:0] hold;
    rep      = '0;
    v        = int'(mv);
    floor_mv = int'(alkd_pkg::NO_KEY_MV) - int'(tol_mv);
    raw      = alkd_pkg::KEY_NONE;
    found    = 1'b0;
    for (int k = 0; k < alkd_pkg::NUM_KEYS; k++) nom[k] = int'(nom_mv[k]);
    if (v < floor_mv) begin
      // midpoint buckets in key order, the last one bounded by the no-key floor
      for (int k = 0; k < alkd_pkg::NUM_KEYS; k++) begin
        thr = (k == alkd_pkg::NUM_KEYS - 1) ? (nom[k] + floor_mv) / 2
                                            : (nom[k] + nom[k+1]) / 2;
        if (!found && v <= thr) begin
          raw   = alkd_pkg::key_t'(k + 1);
          found = 1'b1;
        end
      end
      if (!found) begin
        // nearest nominal, lowest key wins a tie
        best       = alkd_pkg::key_t'(1);
        near_delta = (v > nom[0]) ? v - nom[0] : nom[0] - v;
        for (int k = 1; k < alkd_pkg::NUM_KEYS; k++) begin
          d = (v > nom[k]) ? v - nom[k] : nom[k] - v;
          if (d < near_delta) begin
            near_delta = d;
            best       = alkd_pkg::key_t'(k + 1);
          end
        end
        if (near_delta <= int'(tol_mv) * int'(alkd_pkg::FALLBACK_SCALE)) raw = best;
      end
    end

    if (raw != raw_key) begin
      raw_key    = raw;
      raw_chg_ms = now;
    end
    if (TIME_BITS'(now - raw_chg_ms) >= TIME_BITS'(deb_ms) && raw_key != held_key) begin
      if (held_key == alkd_pkg::KEY_NONE) begin
        held_key = raw_key;
        press_ms = now;
      end else begin
        hold = now - press_ms;
        if (hold >= TIME_BITS'(deb_ms)) begin
          rep.event_valid = 1'b1;
          rep.event_key   = held_key;
          rep.long_hit    = (hold >= TIME_BITS'(long_ms));
          rep.event_ms    = now;
        end
        held_key = raw_key;
        press_ms = (raw_key != alkd_pkg::KEY_NONE) ? now : '0;
      end
    end
    rep.held_key = held_key;
    return rep;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      if (fail_count_o < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      for (int k = 0; k < alkd_pkg::NUM_KEYS; k++) nom_mv[k] = alkd_pkg::NOM_RST[k];
      tol_mv       = alkd_pkg::TOL_RST;
      long_ms      = alkd_pkg::LONG_RST;
      deb_ms       = alkd_pkg::DEB_RST;
      raw_key      = alkd_pkg::KEY_NONE;
      raw_chg_ms   = '0;
      held_key     = alkd_pkg::KEY_NONE;
      press_ms     = '0;
      report_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          alkd_pkg::REG_KEY1, alkd_pkg::REG_KEY2, alkd_pkg::REG_KEY3,
          alkd_pkg::REG_KEY4, alkd_pkg::REG_KEY5:
            nom_mv[cfg_index_i] = cfg_wdata_i[alkd_pkg::MV_BITS-1:0];
          alkd_pkg::REG_TOL:      tol_mv  = cfg_wdata_i[alkd_pkg::TOL_BITS-1:0];
          alkd_pkg::REG_LONG:     long_ms = cfg_wdata_i[alkd_pkg::LONG_BITS-1:0];
          alkd_pkg::REG_DEBOUNCE: deb_ms  = cfg_wdata_i[alkd_pkg::DEB_BITS-1:0];
          default: ;  // unmapped index, dropped
        endcase
      end
      if (in_valid_i && !in_stall_i) report_q.push_back(predict_report(sample_mv_i, now_ms_i));
      if (out_valid_i && !out_stall_i) begin
        if (report_q.size() == 0) begin
          if (fail_count_o < MAX_REPORTS)
            $display("%0t ns: result beat with no sample pending, actual held key %0d",
                     $time, held_key_i);
          fail_count_o++;
        end else begin
          want = report_q.pop_front();
          check_field("event_valid", want.event_valid, event_valid_i);
          check_field("event_key", want.event_key, event_key_i);
          check_field("long_press", want.long_hit, long_press_i);
          check_field("event_ms", want.event_ms, event_ms_i);
          check_field("held_key", want.held_key, held_key_i);
        end
      end
      pending_o = report_q.size();
    end
  end

endmodule

[test/tb_analog_ladder_key_debouncer_top.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for analog_ladder_key_debouncer_top: ladder presses, bounces,
// holds and noise over several register settings. Uses alkd_pkg and alkd_release_checker.
module tb_analog_ladder_key_debouncer_top;

  localparam int unsigned SMP_BITS = alkd_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned T_BITS   = alkd_pkg::TIME_BITS_DEF;
  localparam int SAMPLE_MAX        = (1 << SMP_BITS) - 1;
  localparam int RANDOM_ITEMS      = 1700;
  localparam int ITEMS_PER_SETTING = 340;
  localparam int NUM_DIRECTED      = 22;

  localparam logic [alkd_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_LO = 4'd8;

  // directed walk: bucket edges, floor, fallback, exact debounce and long-press
  // boundaries, key change, and a short hold made by time stepping backward
  localparam int DIR_MV [NUM_DIRECTED] = '{
    0, 4095, 2700, 2699, 550, 551, 551, 551, 2800, 2800, 1300,
    1300, 1800, 1800, 300, 300, 2800, 2800, 800, 800, 2800, 2800};
  localparam int DIR_OFS [NUM_DIRECTED] = '{
    0, 1, 2, 3, 4, 5, 35, 60, 80, 115, 120,
    155, 1100, 1155, 1165, 1200, 1210, 1250, 1300, 1335, 1250, 1340};

  logic                               clk   = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [alkd_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [alkd_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  logic [SMP_BITS-1:0]                sample_mv = '0;
  logic [T_BITS-1:0]                  now_ms    = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               event_valid;
  alkd_pkg::key_t                     event_key;
  logic                               ev_long;
  logic [T_BITS-1:0]                  event_ms;
  alkd_pkg::key_t                     held_key;
  int                                 fail_count;
  int                                 pending;

  int                send_idle_pct  = 33;
  int                recv_stall_pct = 50;
  bit                random_phase   = 1'b0;
  int                random_sent    = 0;
  logic [T_BITS-1:0] t_ms           = '0;
  int                key_mv [1:alkd_pkg::NUM_KEYS];
  int                tol     = alkd_pkg::TOL_RST;
  int                long_ms = alkd_pkg::LONG_RST;
  int                deb     = alkd_pkg::DEB_RST;

  analog_ladder_key_debouncer_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_mv_i   (sample_mv),
    .now_ms_i      (now_ms),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .event_valid_o (event_valid),
    .event_key_o   (event_key),
    .long_press_o  (ev_long),
    .event_ms_o    (event_ms),
    .held_key_o    (held_key)
  );

  alkd_release_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .sample_mv_i   (sample_mv),
    .now_ms_i      (now_ms),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .event_valid_i (event_valid),
    .event_key_i   (event_key),
    .long_press_i  (ev_long),
    .event_ms_i    (event_ms),
    .held_key_i    (held_key),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // one sample beat at the current t_ms; returns at the accepting edge
  task automatic send_at(input logic [SMP_BITS-1:0] mv);
    if (random_phase) begin
      case (random_sent * 3 / RANDOM_ITEMS)
        0: begin
          send_idle_pct  = 33;
          recv_stall_pct = 50;
        end
        1: begin
          send_idle_pct  = 50;
          recv_stall_pct = 33;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      random_sent++;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_mv <= mv;
    now_ms    <= t_ms;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [alkd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [alkd_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      alkd_pkg::REG_TOL:      tol     = int'(data[alkd_pkg::TOL_BITS-1:0]);
      alkd_pkg::REG_LONG:     long_ms = int'(data[alkd_pkg::LONG_BITS-1:0]);
      alkd_pkg::REG_DEBOUNCE: deb     = int'(data[alkd_pkg::DEB_BITS-1:0]);
      default: if (idx <= alkd_pkg::REG_KEY5)
        key_mv[int'(idx) + 1] = int'(data[alkd_pkg::MV_BITS-1:0]);
    endcase
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register settings; unused upper data bits carry junk that must be dropped
  task automatic program_setting(input int which);
    int                                 kv [alkd_pkg::NUM_KEYS];
    int                                 tol_v, long_v, deb_v;
    logic [alkd_pkg::CFG_DATA_BITS-1:0] d;
    case (which)
      1: begin
        kv = '{200, 700, 1200, 1700, 2200};
        tol_v = 60; long_v = 250; deb_v = 15;
      end
      2: begin
        kv = '{0, 1, 2047, 4094, 4095};
        tol_v = 0; long_v = 0; deb_v = 0;
      end
      3: begin
        // descending and unordered nominals
        kv = '{4095, 2500, 0, 1500, 600};
        tol_v = 1023; long_v = 65535; deb_v = 1023;
      end
      default: begin
        foreach (kv[i]) kv[i] = $urandom_range(0, 4095);
        tol_v  = $urandom_range(0, 300);
        long_v = $urandom_range(0, 3000);
        deb_v  = $urandom_range(0, 100);
      end
    endcase
    write_reg(REG_UNUSED_LO + $urandom_range(0, 7), $urandom);
    for (int i = 0; i < alkd_pkg::NUM_KEYS; i++) begin
      d = $urandom;
      d[alkd_pkg::MV_BITS-1:0] = alkd_pkg::MV_BITS'(kv[i]);
      write_reg(alkd_pkg::REG_KEY1 + i, d);
    end
    d = $urandom;
    d[alkd_pkg::TOL_BITS-1:0] = alkd_pkg::TOL_BITS'(tol_v);
    write_reg(alkd_pkg::REG_TOL, d);
    write_reg(alkd_pkg::REG_LONG, alkd_pkg::CFG_DATA_BITS'(long_v));
    d = $urandom;
    d[alkd_pkg::DEB_BITS-1:0] = alkd_pkg::DEB_BITS'(deb_v);
    write_reg(alkd_pkg::REG_DEBOUNCE, d);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SMP_BITS-1:0] key_sample(input int k);
    int v, jit;
    if ($urandom_range(19) == 0) return SMP_BITS'($urandom);
    jit = tol / 2;
    v   = key_mv[k] + int'($urandom_range(0, 2 * jit)) - jit;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SMP_BITS'(v);
  endfunction

  function automatic logic [SMP_BITS-1:0] release_sample();
    return SMP_BITS'($urandom_range(int'(alkd_pkg::NO_KEY_MV) - tol, SAMPLE_MAX));
  endfunction

  // bounce, stable hold of one key, then release or straight into the next press
  task automatic press_sequence();
    int k, sel, hold, span, stride, elapsed, dt;
    k = $urandom_range(1, alkd_pkg::NUM_KEYS);
    repeat ($urandom_range(0, 3)) begin
      t_ms += $urandom_range(0, deb / 2 + 1);
      send_at($urandom_range(1) ? key_sample($urandom_range(1, alkd_pkg::NUM_KEYS))
                                : release_sample());
    end
    sel = $urandom_range(9);
    if (sel < 2) hold = $urandom_range(0, deb);
    else if (sel < 7) hold = deb + $urandom_range(0, (long_ms > deb) ? long_ms - deb : 10);
    else hold = long_ms + $urandom_range(0, long_ms / 4 + deb + 5);
    span    = deb + hold;
    stride  = span / $urandom_range(2, 7) + 1;
    elapsed = 0;
    t_ms += $urandom_range(1, stride);
    send_at(key_sample(k));
    while (elapsed < span) begin
      dt = $urandom_range(1, 2 * stride);
      t_ms += dt;
      elapsed += dt;
      send_at(key_sample(k));
    end
    if ($urandom_range(9) < 7) begin
      span    = deb + $urandom_range(0, deb / 2 + 3);
      stride  = span / $urandom_range(1, 4) + 1;
      elapsed = 0;
      t_ms += $urandom_range(1, stride);
      send_at(release_sample());
      while (elapsed <= span) begin
        dt = $urandom_range(1, 2 * stride);
        t_ms += dt;
        elapsed += dt;
        send_at(release_sample());
      end
    end
  endtask

  // raw samples with jumps, backward steps and wraps of the time base
  task automatic noise_sequence();
    int sel;
    repeat ($urandom_range(3, 8)) begin
      sel = $urandom_range(9);
      if (sel == 0) t_ms = $urandom;
      else if (sel == 1) t_ms -= $urandom_range(1, 2 * deb + 50);
      else t_ms += $urandom_range(0, 2 * deb + 5);
      send_at(SMP_BITS'($urandom));
    end
  endtask

  task automatic run_key_traffic();
    int stop_at;
    stop_at = random_sent + ITEMS_PER_SETTING;
    if ($urandom_range(1)) begin
      t_ms = '1;
      t_ms -= $urandom_range(0, 5000);
    end
    while (random_sent < stop_at) begin
      if ($urandom_range(99) < 80) press_sequence();
      else noise_sequence();
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [T_BITS-1:0] base;
    for (int k = 1; k <= alkd_pkg::NUM_KEYS; k++) key_mv[k] = int'(alkd_pkg::NOM_RST[k-1]);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    base = '1;
    base -= 63;  // directed walk crosses the time wrap
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      t_ms = base + DIR_OFS[i];
      send_at(SMP_BITS'(DIR_MV[i]));
    end

    random_phase = 1'b1;
    run_key_traffic();
    for (int s = 1; s <= 4; s++) begin
      wait_results_drained();
      program_setting(s);
      run_key_traffic();
    end
    wait_results_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/alkd_pkg.sv
hdl/alkd_decode.sv
hdl/analog_ladder_key_debouncer_top.sv
test/alkd_release_checker.sv
test/tb_analog_ladder_key_debouncer_top.sv
